// ----- src/kwm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types and codes for the k-way sorted merge block.
// ----------------------------------------------------------------------------
package kwm_pkg;

	localparam logic ACT_APPEND = 1'b0;
	localparam logic ACT_POP    = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic               action;
		logic [2:0]         list_index;
		logic signed [31:0] item_value;
	} item_t;

	typedef struct packed {
		logic signed [31:0] merged_value;
		status_t            status;
	} result_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_APP,
		S_SCAN,
		S_DRAIN,
		S_DONE
	} state_t;

endpackage

// ----- src/k_way_sorted_merge.sv -----
`timescale 1ns / 1ps
// An append is accepted in S_IDLE and written in S_APP; a pop scans the heads
// in S_SCAN and S_DRAIN and writes back; both then raise result_valid from S_DONE
// (later while an earlier result is stalled). The next transaction is taken
// once S_DONE returns to S_IDLE; a pop reads one list head per cycle through the
// single pointer-RAM and store read ports and one comparator.
// ----------------------------------------------------------------------------
// k_way_sorted_merge
// Keeps NUM_LISTS sorted lists and pops the smallest head on request.
// Reset clears state and the per-list valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module k_way_sorted_merge
	import kwm_pkg::*;
#(
	parameter int NUM_LISTS  = 8,
	parameter int LIST_DEPTH = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int LW     = $clog2(NUM_LISTS);
	localparam int SAW    = $clog2(NUM_LISTS * LIST_DEPTH);
	localparam int META_W = 2 * $clog2(LIST_DEPTH) + $clog2(LIST_DEPTH + 1);

	logic               meta_wr_en, meta_rd_en;
	logic [LW-1:0]      meta_wr_addr, meta_rd_addr;
	logic [META_W-1:0]  meta_wr_data, meta_rd_data;
	logic               store_wr_en, store_rd_en;
	logic [SAW-1:0]     store_wr_addr, store_rd_addr;
	logic signed [31:0] store_wr_data, store_rd_data;

	kwm_seq #(
		.NUM_LISTS  (NUM_LISTS),
		.LIST_DEPTH (LIST_DEPTH)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.item          (item),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result        (result),
		.meta_wr_en    (meta_wr_en),
		.meta_wr_addr  (meta_wr_addr),
		.meta_wr_data  (meta_wr_data),
		.meta_rd_en    (meta_rd_en),
		.meta_rd_addr  (meta_rd_addr),
		.meta_rd_data  (meta_rd_data),
		.store_wr_en   (store_wr_en),
		.store_wr_addr (store_wr_addr),
		.store_wr_data (store_wr_data),
		.store_rd_en   (store_rd_en),
		.store_rd_addr (store_rd_addr),
		.store_rd_data (store_rd_data)
	);

	kwm_meta_ram #(
		.NUM_LISTS (NUM_LISTS),
		.META_W    (META_W)
	) u_meta (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (meta_wr_en),
		.wr_addr (meta_wr_addr),
		.wr_data (meta_wr_data),
		.rd_en   (meta_rd_en),
		.rd_addr (meta_rd_addr),
		.rd_data (meta_rd_data)
	);

	kwm_store_ram #(
		.NUM_LISTS  (NUM_LISTS),
		.LIST_DEPTH (LIST_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (store_wr_en),
		.wr_addr (store_wr_addr),
		.wr_data (store_wr_data),
		.rd_en   (store_rd_en),
		.rd_addr (store_rd_addr),
		.rd_data (store_rd_data)
	);

endmodule

// ----- src/kwm_store_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_store_ram
// Element storage for all lists: one write port, one registered read port.
// ----------------------------------------------------------------------------
module kwm_store_ram #(
	parameter int NUM_LISTS  = 8,
	parameter int LIST_DEPTH = 64
) (
	input  logic                                        clk,
	input  logic                                        wr_en,
	input  logic [$clog2(NUM_LISTS*LIST_DEPTH)-1:0]     wr_addr,
	input  logic signed [31:0]                          wr_data,
	input  logic                                        rd_en,
	input  logic [$clog2(NUM_LISTS*LIST_DEPTH)-1:0]     rd_addr,
	output logic signed [31:0]                          rd_data
);

	localparam int ENTRIES = NUM_LISTS * LIST_DEPTH;

	logic signed [31:0] mem [ENTRIES];
	logic signed [31:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- src/kwm_meta_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_meta_ram
// Per-list head, tail and fill count. Entries never written read as zero.
// ----------------------------------------------------------------------------
module kwm_meta_ram #(
	parameter int NUM_LISTS = 8,
	parameter int META_W    = 19
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [$clog2(NUM_LISTS)-1:0] wr_addr,
	input  logic [META_W-1:0]            wr_data,
	input  logic                         rd_en,
	input  logic [$clog2(NUM_LISTS)-1:0] rd_addr,
	output logic [META_W-1:0]            rd_data
);

	logic [META_W-1:0]    mem [NUM_LISTS];
	logic [NUM_LISTS-1:0] valid_q;
	logic [META_W-1:0]    rd_data_q;
	logic                 rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

// ----- src/kwm_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_seq
// Sequencer with one shared comparator: appends, scans list heads for pops,
// and holds the result register.
// ----------------------------------------------------------------------------
module kwm_seq
	import kwm_pkg::*;
#(
	parameter int NUM_LISTS  = 8,
	parameter int LIST_DEPTH = 64
) (
	input  logic                                                   clk,
	input  logic                                                   arst_n,
	input  logic                                                   item_valid,
	output logic                                                   item_stall,
	input  item_t                                                  item,
	output logic                                                   result_valid,
	input  logic                                                   result_stall,
	output result_t                                                result,
	output logic                                                   meta_wr_en,
	output logic [$clog2(NUM_LISTS)-1:0]                           meta_wr_addr,
	output logic [2*$clog2(LIST_DEPTH)+$clog2(LIST_DEPTH+1)-1:0]   meta_wr_data,
	output logic                                                   meta_rd_en,
	output logic [$clog2(NUM_LISTS)-1:0]                           meta_rd_addr,
	input  logic [2*$clog2(LIST_DEPTH)+$clog2(LIST_DEPTH+1)-1:0]   meta_rd_data,
	output logic                                                   store_wr_en,
	output logic [$clog2(NUM_LISTS*LIST_DEPTH)-1:0]                store_wr_addr,
	output logic signed [31:0]                                     store_wr_data,
	output logic                                                   store_rd_en,
	output logic [$clog2(NUM_LISTS*LIST_DEPTH)-1:0]                store_rd_addr,
	input  logic signed [31:0]                                     store_rd_data
);

	localparam int LW  = $clog2(NUM_LISTS);
	localparam int PW  = $clog2(LIST_DEPTH);
	localparam int CW  = $clog2(LIST_DEPTH + 1);
	localparam int SAW = $clog2(NUM_LISTS * LIST_DEPTH);

	typedef struct packed {
		logic [PW-1:0] head;
		logic [PW-1:0] tail;
		logic [CW-1:0] count;
	} meta_t;

	function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
		return (p == PW'(LIST_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [SAW-1:0] slot_addr(input logic [LW-1:0] l,
		input logic [PW-1:0] p);
		return SAW'(SAW'(l) * SAW'(LIST_DEPTH)) + SAW'(p);
	endfunction

	state_t             state_q, state_d;
	logic               accept;
	logic [LW-1:0]      idx_q;
	logic signed [31:0] value_q;
	logic               oor_q;
	logic [LW-1:0]      scan_q;
	logic               v_s1, v_s2;
	logic [LW-1:0]      idx_s1, idx_s2;
	meta_t              meta_s2;
	meta_t              meta_rd;
	logic               found_q;
	logic [LW-1:0]      best_idx_q;
	logic signed [31:0] best_val_q;
	meta_t              best_meta_q;
	logic               take;
	logic               drain_done;
	logic               app_full;
	logic               res_ld;
	result_t            res_d, res_q;
	logic               out_valid_q;
	result_t            out_data_q;
	meta_t              meta_wr;

	assign accept     = (state_q == S_IDLE) && item_valid;
	assign meta_rd    = meta_t'(meta_rd_data);
	assign drain_done = (state_q == S_DRAIN) && !v_s1 && !v_s2;
	assign app_full   = oor_q || (meta_rd.count == CW'(LIST_DEPTH));

	// shared comparator: lower index wins ties since scan runs upward
	assign take = v_s2 && (meta_s2.count != '0)
		&& (!found_q || (store_rd_data < best_val_q));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					state_d = (item.action == ACT_POP) ? S_SCAN : S_APP;
				end
			end
			S_APP: begin
				state_d = S_DONE;
			end
			S_SCAN: begin
				if (scan_q == LW'(NUM_LISTS - 1)) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || !result_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		meta_rd_en    = 1'b0;
		meta_rd_addr  = scan_q;
		meta_wr_en    = 1'b0;
		meta_wr_addr  = idx_q;
		meta_wr       = meta_rd;
		store_wr_en   = 1'b0;
		store_wr_addr = slot_addr(idx_q, meta_rd.tail);
		store_wr_data = value_q;
		res_ld        = 1'b0;
		res_d         = '{merged_value: '0, status: STAT_OK};
		unique case (state_q)
			S_IDLE: begin
				meta_rd_en   = item_valid;
				meta_rd_addr = LW'(item.list_index);
			end
			S_APP: begin
				res_ld = 1'b1;
				if (app_full) begin
					res_d.status = STAT_FULL;
				end else begin
					store_wr_en   = 1'b1;
					meta_wr_en    = 1'b1;
					meta_wr.tail  = advance(meta_rd.tail);
					meta_wr.count = meta_rd.count + 1'b1;
				end
			end
			S_SCAN: begin
				meta_rd_en = 1'b1;
			end
			S_DRAIN: begin
				if (drain_done) begin
					res_ld       = 1'b1;
					meta_wr_addr = best_idx_q;
					meta_wr      = best_meta_q;
					if (found_q) begin
						meta_wr_en         = 1'b1;
						meta_wr.head       = advance(best_meta_q.head);
						meta_wr.count      = best_meta_q.count - 1'b1;
						res_d.merged_value = best_val_q;
					end else begin
						res_d.status = STAT_EMPTY;
					end
				end
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign meta_wr_data  = meta_wr;
	assign store_rd_en   = v_s1;
	assign store_rd_addr = slot_addr(idx_s1, meta_rd.head);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			scan_q      <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == S_SCAN);
			v_s2    <= v_s1;
			if (accept) begin
				scan_q  <= '0;
				found_q <= 1'b0;
			end else if (state_q == S_SCAN) begin
				scan_q <= scan_q + 1'b1;
			end
			if (take) begin
				found_q <= 1'b1;
			end
			// hold the result until taken; reload from DONE only when free
			if (state_q == S_DONE && (!out_valid_q || !result_stall)) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q   <= LW'(item.list_index);
			value_q <= item.item_value;
			oor_q   <= (32'(item.list_index) >= 32'(NUM_LISTS));
		end
		idx_s1  <= scan_q;
		idx_s2  <= idx_s1;
		meta_s2 <= meta_rd;
		if (take) begin
			best_idx_q  <= idx_s2;
			best_val_q  <= store_rd_data;
			best_meta_q <= meta_s2;
		end
		if (res_ld) begin
			res_q <= res_d;
		end
		if (state_q == S_DONE && (!out_valid_q || !result_stall)) begin
			out_data_q <= res_q;
		end
	end

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_data_q;

	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status != STAT_OK) |-> result.merged_value == '0)
		else $error("merged_value not zero on failing status");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("block ready right after taking a transaction");

	a_pipe_in_pop: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (state_q == S_SCAN) || (state_q == S_DRAIN))
		else $error("head scan stage active outside a pop");

	a_meta_wr_state: assert property (@(posedge clk) disable iff (!arst_n)
		meta_wr_en |-> (state_q == S_APP) || drain_done)
		else $error("list pointer write outside append or pop writeback");

	a_no_store_wr_full: assert property (@(posedge clk) disable iff (!arst_n)
		store_wr_en |-> !oor_q && (meta_rd.count < CW'(LIST_DEPTH)))
		else $error("store write into a full or missing list");

endmodule
